>>> rtl/core/bira_pkg.sv
// Shared constants, codes and helper functions for the beat interval rate averager.
`timescale 1ns / 1ps

package bira_pkg;

	// Rate slot ring
	localparam int RATE_SLOTS = 8;
	localparam int SLOT_AW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;

	// Field widths
	localparam int TIME_W = 32;
	localparam int IVAL_W = 16;
	localparam int RATE_W = 16;
	localparam int CNT_W = 4;
	localparam int WHOLE_W = 8;
	localparam int SUM_W = 11;
	localparam int CFG_W = 16;
	localparam int CFG_AW = 3;

	// Serial divider: quotient register width and step count
	localparam int QUO_W = 24;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	// Rate constants in Q8
	localparam logic [QUO_W-1:0] BPM_NUM_Q8 = 24'd15360000;
	localparam logic [QUO_W-1:0] BPM_LOW_Q8 = 24'd7680;
	localparam logic [QUO_W-1:0] BPM_HIGH_Q8 = 24'd51200;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_MIN_IVAL = 3'd0;
	localparam logic [CFG_AW-1:0] REG_MAX_IVAL = 3'd1;
	localparam logic [CFG_AW-1:0] REG_WINDOW = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SENS = 3'd3;

	// Register reset values
	localparam logic [IVAL_W-1:0] MIN_IVAL_RST = 16'd300;
	localparam logic [IVAL_W-1:0] MAX_IVAL_RST = 16'd2000;
	localparam logic [3:0] WINDOW_RST = 4'd4;
	localparam logic [3:0] SENS_RST = 4'd5;

	// Verdict codes
	localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
	localparam logic [2:0] VERDICT_FIRST = 3'd1;
	localparam logic [2:0] VERDICT_INTERVAL = 3'd2;
	localparam logic [2:0] VERDICT_RANGE = 3'd3;
	localparam logic [2:0] VERDICT_TOLERANCE = 3'd4;

	// Operation codes
	localparam logic OP_BEAT = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Tolerance in Q16 for a sensitivity setting, clamped to 1..10
	function automatic logic [15:0] tol_q16(input logic [3:0] sens);
		int sc;
		sc = (sens < 4'd1) ? 1 : ((sens > 4'd10) ? 10 : int'(sens));
		return 16'(13107 + (sc - 1) * 2185);
	endfunction

	// Window size clamped to 1..RATE_SLOTS
	function automatic logic [CNT_W-1:0] clamp_win(input logic [3:0] ws);
		logic [CNT_W-1:0] w;
		if (ws == 4'd0) begin
			w = CNT_W'(1);
		end else if (int'(ws) > RATE_SLOTS) begin
			w = CNT_W'(RATE_SLOTS);
		end else begin
			w = CNT_W'(ws);
		end
		return w;
	endfunction

endpackage

>>> rtl/core/beat_interval_rate_averager.sv
// Beat interval rate averager: interval checks, rate ring and running average over a serial divider.
// A restart, a first beat or a beat rejected on its interval goes straight to output; one rejected
// on rate or tolerance passes the divider and its checks, and an accepted beat also the slot update,
// the sum sweep and a second division: one radix-2 restoring divider, one quotient bit per cycle
// over 24 steps, is used twice (15360000 / interval, then slot sum * 256 / fill) and a sweep reads
// the rate slots through a registered port to form the sum. One beat is worked on at a time; the
// next is taken as soon as the result word is placed in the output register, even while that word
// is still stalled. Configuration writes take effect at once and should be made while idle.
`timescale 1ns / 1ps

module beat_interval_rate_averager (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] beat_time_ms,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [2:0]  verdict,
	output logic [15:0] instant_bpm_q8,
	output logic [15:0] average_bpm_q8,
	output logic [3:0]  slots_filled
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVR = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_TOL  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;
	localparam logic [2:0] ST_DIVA = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	// configuration registers
	logic [bira_pkg::IVAL_W-1:0] min_ival_q;
	logic [bira_pkg::IVAL_W-1:0] max_ival_q;
	logic [3:0]                  window_q;
	logic [3:0]                  sens_q;

	// block state
	logic [2:0]                   state_q;
	logic [bira_pkg::TIME_W-1:0]  last_q;
	logic [bira_pkg::CNT_W-1:0]   next_q;
	logic [bira_pkg::CNT_W-1:0]   filled_q;
	logic [bira_pkg::RATE_W-1:0]  avg_q;
	logic [bira_pkg::RATE_W-1:0]  inst_q;
	logic [bira_pkg::WHOLE_W-1:0] slot_q [bira_pkg::RATE_SLOTS];

	// working registers
	logic [bira_pkg::QUO_W-1:0]   quo_q;
	logic [bira_pkg::IVAL_W-1:0]  rem_q;
	logic [bira_pkg::IVAL_W-1:0]  dvs_q;
	logic [bira_pkg::STEP_W-1:0]  step_q;
	logic [bira_pkg::RATE_W-1:0]  bpm_q;
	logic [31:0]                  prod_q;
	logic [bira_pkg::CNT_W-1:0]   idx_q;
	logic [bira_pkg::WHOLE_W-1:0] rd_q;
	logic                         rdv_q;
	logic [bira_pkg::SUM_W-1:0]   acc_q;
	logic [2:0]                   verdict_q;

	// output register
	logic                         out_valid_q;
	logic                         accepted_q;
	logic [2:0]                   verdict_out_q;
	logic [bira_pkg::RATE_W-1:0]  inst_out_q;
	logic [bira_pkg::RATE_W-1:0]  avg_out_q;
	logic [bira_pkg::CNT_W-1:0]   filled_out_q;

	logic                         take;
	logic [bira_pkg::TIME_W-1:0]  delta;
	logic                         ival_bad;
	logic [bira_pkg::IVAL_W:0]    shifted;
	logic                         qbit;
	logic [bira_pkg::IVAL_W:0]    rem_diff;
	logic [bira_pkg::CNT_W-1:0]   win;
	logic [32:0]                  hi_bound;
	logic [32:0]                  lo_bound;
	logic [32:0]                  lhs;
	logic [bira_pkg::SUM_W-1:0]   sum_next;
	logic                         fin_load;

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign delta = beat_time_ms - last_q;
	assign ival_bad = (delta <= {16'd0, min_ival_q}) || (delta >= {16'd0, max_ival_q});

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, quo_q[bira_pkg::QUO_W-1]};
	assign qbit = (shifted >= {1'b0, dvs_q});
	assign rem_diff = shifted - {1'b0, dvs_q};

	assign win = bira_pkg::clamp_win(window_q);

	assign lhs = {1'b0, bpm_q, 16'd0};
	assign hi_bound = {1'b0, avg_q, 16'd0} + {1'b0, prod_q};
	assign lo_bound = {1'b0, avg_q, 16'd0} - {1'b0, prod_q};

	assign sum_next = acc_q + (rdv_q ? bira_pkg::SUM_W'(rd_q) : bira_pkg::SUM_W'(0));

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ival_q <= bira_pkg::MIN_IVAL_RST;
			max_ival_q <= bira_pkg::MAX_IVAL_RST;
			window_q <= bira_pkg::WINDOW_RST;
			sens_q <= bira_pkg::SENS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				bira_pkg::REG_MIN_IVAL: min_ival_q <= cfg_data;
				bira_pkg::REG_MAX_IVAL: max_ival_q <= cfg_data;
				bira_pkg::REG_WINDOW: window_q <= cfg_data[3:0];
				bira_pkg::REG_SENS: sens_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q <= '0;
			next_q <= '0;
			filled_q <= '0;
			avg_q <= '0;
			inst_q <= '0;
			step_q <= '0;
			idx_q <= '0;
			rdv_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (operation == bira_pkg::OP_RESTART) begin
							last_q <= '0;
							next_q <= '0;
							filled_q <= '0;
							avg_q <= '0;
							inst_q <= '0;
							state_q <= ST_FIN;
						end else if (last_q == '0) begin
							last_q <= beat_time_ms;
							state_q <= ST_FIN;
						end else begin
							last_q <= beat_time_ms;
							step_q <= '0;
							state_q <= ival_bad ? ST_FIN : ST_DIVR;
						end
					end
				end
				ST_DIVR: begin
					step_q <= step_q + 1'b1;
					if (step_q == bira_pkg::LAST_STEP) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (quo_q < bira_pkg::BPM_LOW_Q8 || quo_q > bira_pkg::BPM_HIGH_Q8) begin
						state_q <= ST_FIN;
					end else if (avg_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						state_q <= ST_TOL;
					end
				end
				ST_TOL: begin
					state_q <= (lhs > hi_bound || lhs < lo_bound) ? ST_FIN : ST_UPD;
				end
				ST_UPD: begin
					inst_q <= bpm_q;
					next_q <= next_q + 1'b1;
					if (filled_q < win) begin
						filled_q <= filled_q + 1'b1;
					end
					idx_q <= '0;
					rdv_q <= 1'b0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// wrap the pointer into the window, one subtraction a cycle
					if (next_q >= win) begin
						next_q <= next_q - win;
					end
					if (idx_q == bira_pkg::CNT_W'(bira_pkg::RATE_SLOTS)) begin
						rdv_q <= 1'b0;
						step_q <= '0;
						state_q <= ST_DIVA;
					end else begin
						rdv_q <= (idx_q < filled_q);
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIVA: begin
					step_q <= step_q + 1'b1;
					if (step_q == bira_pkg::LAST_STEP) begin
						avg_q <= {quo_q[bira_pkg::RATE_W-2:0], qbit};
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, slot store and output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					quo_q <= bira_pkg::BPM_NUM_Q8;
					rem_q <= '0;
					dvs_q <= delta[bira_pkg::IVAL_W-1:0];
					acc_q <= '0;
					if (operation == bira_pkg::OP_RESTART || last_q == '0) begin
						verdict_q <= bira_pkg::VERDICT_FIRST;
					end else if (ival_bad) begin
						verdict_q <= bira_pkg::VERDICT_INTERVAL;
					end else begin
						verdict_q <= bira_pkg::VERDICT_ACCEPT;
					end
				end
			end
			ST_DIVR, ST_DIVA: begin
				quo_q <= {quo_q[bira_pkg::QUO_W-2:0], qbit};
				rem_q <= qbit ? rem_diff[bira_pkg::IVAL_W-1:0] : shifted[bira_pkg::IVAL_W-1:0];
			end
			ST_CHK: begin
				bpm_q <= quo_q[bira_pkg::RATE_W-1:0];
				prod_q <= 32'(avg_q) * 32'(bira_pkg::tol_q16(sens_q));
				if (quo_q < bira_pkg::BPM_LOW_Q8 || quo_q > bira_pkg::BPM_HIGH_Q8) begin
					verdict_q <= bira_pkg::VERDICT_RANGE;
				end
			end
			ST_TOL: begin
				if (lhs > hi_bound || lhs < lo_bound) begin
					verdict_q <= bira_pkg::VERDICT_TOLERANCE;
				end
			end
			ST_UPD: begin
				slot_q[next_q[bira_pkg::SLOT_AW-1:0]] <= bpm_q[15:8];
			end
			ST_SUM: begin
				acc_q <= sum_next;
				if (idx_q != bira_pkg::CNT_W'(bira_pkg::RATE_SLOTS)) begin
					rd_q <= slot_q[idx_q[bira_pkg::SLOT_AW-1:0]];
				end else begin
					// sum * 256 over the fill count
					quo_q <= {5'd0, sum_next, 8'd0};
					rem_q <= '0;
					dvs_q <= bira_pkg::IVAL_W'(filled_q);
				end
			end
			default: ;
		endcase
		if (fin_load) begin
			accepted_q <= (verdict_q == bira_pkg::VERDICT_ACCEPT);
			verdict_out_q <= verdict_q;
			inst_out_q <= inst_q;
			avg_out_q <= avg_q;
			filled_out_q <= filled_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = accepted_q;
	assign verdict = verdict_out_q;
	assign instant_bpm_q8 = inst_out_q;
	assign average_bpm_q8 = avg_out_q;
	assign slots_filled = filled_out_q;

	// the divider remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVR || state_q == ST_DIVA) && step_q != '0 |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	// between words the pointer lies inside the ring and the fill never exceeds the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |->
			next_q < bira_pkg::CNT_W'(bira_pkg::RATE_SLOTS)
			&& filled_q <= bira_pkg::CNT_W'(bira_pkg::RATE_SLOTS))
		else $error("rate ring pointer or fill out of range");

	// an accepted restart empties the ring and the rates
	assert property (@(posedge clk) disable iff (!arst_n)
		take && operation == bira_pkg::OP_RESTART |=>
			filled_q == '0 && avg_q == '0 && inst_q == '0 && last_q == '0)
		else $error("restart did not clear the rate state");

	// the accepted flag agrees with the verdict of the word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> accepted_q == (verdict_out_q == bira_pkg::VERDICT_ACCEPT))
		else $error("accepted flag disagrees with verdict");

endmodule
